// ===== rtl/lmch_pkg.sv =====
// ----------------------------------------------------------------------------
// Lozi map cell histogram package
// Shared fixed-point widths, register reset values, opcode and register
// index codes, and the command and status words between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package lmch_pkg;

    // Fixed-point format of the map coefficients, origin and points: signed Q4.28.
    localparam int FRAC_BITS = 28;
    localparam int Q_W       = 32;
    localparam int W_W       = 31;
    localparam int OFF_W     = 31;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Product, map accumulator and cell search widths.
    localparam int PROD_W = 64;
    localparam int ACC_W  = 38;
    localparam int D_W    = 40;

    // Register reset values.
    localparam logic [Q_W-1:0] ALPHA_RST  = Q_W'(496607642);
    localparam logic [Q_W-1:0] BETA_RST   = Q_W'(80530637);
    localparam logic [Q_W-1:0] ORIGIN_RST = Q_W'(-343510077);
    localparam logic [W_W-1:0] WIDTH_RST  = W_W'(10905190);

    // The constant 1.0 in the map accumulator format.
    localparam logic [ACC_W-1:0] ACC_ONE = ACC_W'(1 << FRAC_BITS);

    // Operation codes of an input word.
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_MAP   = 2'd1,
        OP_READ  = 2'd2
    } t_opcode;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA  = 2'd0,
        CFG_BETA   = 2'd1,
        CFG_ORIGIN = 2'd2,
        CFG_WIDTH  = 2'd3
    } t_cfg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic form_q;
        logic form_p;
        logic mul_a;
        logic mul_b;
        logic acc_add;
        logic div_init_row;
        logic div_init_col;
        logic div_step;
        logic save_row;
        logic save_col;
        logic mem_rd;
        logic mem_cap;
        logic clr_step;
        logic out_load;
    } t_lmch_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
    } t_lmch_status;

endpackage

// ===== rtl/lmch_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lmch_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lmch_ctrl.sv =====
// ----------------------------------------------------------------------------
// Lozi map cell histogram controller
// Sequences one word at a time through the datapath: point forming,
// map multiplies, two cell searches, counter read or update, and the clearing
// sweep. Owns the output valid flag.
// ----------------------------------------------------------------------------
module lmch_ctrl
    import lmch_pkg::*;
#(
    parameter int GRID_SIDE = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [1:0]   i_opcode,
    input  logic         i_out_ready,
    output logic         o_out_valid,
    output t_lmch_cmd    o_cmd,
    input  t_lmch_status i_status
);

    localparam int IDX_W  = $clog2(GRID_SIDE);
    localparam int STEP_W = $clog2(IDX_W + 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(IDX_W - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_POS_Q,
        S_POS_P,
        S_MUL_A,
        S_MUL_B,
        S_ACC,
        S_ROW_INIT,
        S_ROW_DIV,
        S_ROW_END,
        S_COL_INIT,
        S_COL_DIV,
        S_COL_END,
        S_MEM_RD,
        S_MEM_CAP,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_user_clr, n_user_clr;
    logic               r_out_valid, n_out_valid;
    logic               in_accept;
    logic               out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // Next state and command decode.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_user_clr  = r_user_clr;
        n_out_valid = r_out_valid;
        o_cmd       = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_user_clr    = 1'b1;
                    case (t_opcode'(i_opcode))
                        OP_CLEAR: n_state = S_CLEAR;
                        OP_MAP:   n_state = S_POS_Q;
                        OP_READ:  n_state = S_MEM_RD;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = r_user_clr ? S_DONE : S_IDLE;
                end
            end
            S_POS_Q: begin
                o_cmd.form_q = 1'b1;
                n_state      = S_POS_P;
            end
            S_POS_P: begin
                o_cmd.form_p = 1'b1;
                n_state      = S_MUL_A;
            end
            S_MUL_A: begin
                o_cmd.mul_a = 1'b1;
                n_state     = S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.mul_b = 1'b1;
                n_state     = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_add = 1'b1;
                n_state       = S_ROW_INIT;
            end
            S_ROW_INIT: begin
                o_cmd.div_init_row = 1'b1;
                n_step             = '0;
                n_state            = S_ROW_DIV;
            end
            S_ROW_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = S_ROW_END;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_ROW_END: begin
                o_cmd.save_row = 1'b1;
                n_state        = S_COL_INIT;
            end
            S_COL_INIT: begin
                o_cmd.div_init_col = 1'b1;
                n_step             = '0;
                n_state            = S_COL_DIV;
            end
            S_COL_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = S_COL_END;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_COL_END: begin
                o_cmd.save_col = 1'b1;
                n_state        = S_MEM_RD;
            end
            S_MEM_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_MEM_CAP;
            end
            S_MEM_CAP: begin
                o_cmd.mem_cap = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs. Reset starts the clearing sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_step      <= '0;
            r_user_clr  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_user_clr  <= n_user_clr;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef ASSERT_OFF
    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a pending word");

    // A map word goes straight to point forming.
    a_map_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_opcode == OP_MAP)) |=> (r_state == S_POS_Q))
        else $error("map word did not start point forming");

    // The divide step counter stays within one quotient.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ROW_DIV) || (r_state == S_COL_DIV)) |-> (r_step <= STEP_LAST))
        else $error("divide step counter out of range");
`endif

endmodule

// ===== rtl/lmch_dp.sv =====
// ----------------------------------------------------------------------------
// Lozi map cell histogram datapath
// Configuration registers, point forming, the shared map multiplier, the
// shared restoring cell-search divider, the counter RAM and the output
// register.
// ----------------------------------------------------------------------------
module lmch_dp
    import lmch_pkg::*;
#(
    parameter int GRID_SIDE  = 64,
    parameter int COUNT_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]             i_cfg_wdata,
    input  logic [1:0]                   i_opcode,
    input  logic [$clog2(GRID_SIDE)-1:0] i_cell_q,
    input  logic [$clog2(GRID_SIDE)-1:0] i_cell_p,
    input  logic [OFF_W-1:0]             i_offset_q,
    input  logic [OFF_W-1:0]             i_offset_p,
    input  t_lmch_cmd                    i_cmd,
    output t_lmch_status                 o_status,
    output logic [COUNT_BITS-1:0]        o_count,
    output logic [$clog2(GRID_SIDE)-1:0] o_bin_q,
    output logic [$clog2(GRID_SIDE)-1:0] o_bin_p,
    output logic                         o_hit
);

    localparam int IDX_W  = $clog2(GRID_SIDE);
    localparam int CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int MUL_W  = IDX_W + W_W;
    localparam int SUM_W  = MUL_W + 2;

    // Configuration registers.
    logic [Q_W-1:0]        r_alpha, r_beta, r_origin;
    logic [W_W-1:0]        r_width;

    // Captured input word.
    logic [1:0]            r_opcode;
    logic [IDX_W-1:0]      r_cq, r_cp;
    logic [OFF_W-1:0]      r_oq, r_op;
    logic [W_W-1:0]        r_w;
    logic [D_W-1:0]        r_lim;

    // Map arithmetic.
    logic [Q_W-1:0]        r_q, r_p;
    logic signed [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]      r_acc;

    // Cell search.
    logic [D_W-1:0]        r_rem, r_dvs;
    logic [IDX_W-1:0]      r_quo, r_row, r_col;
    logic                  r_miss;

    // Counter access and clearing sweep.
    logic [ADDR_W-1:0]     r_addr, r_clr_addr;
    logic                  r_in_grid;
    logic [COUNT_BITS-1:0] r_cnt;

    // Output register.
    logic [COUNT_BITS-1:0] r_out_count, n_out_count;
    logic [IDX_W-1:0]      r_out_bin_q, n_out_bin_q, r_out_bin_p, n_out_bin_p;
    logic                  r_out_hit, n_out_hit;

    // Combinational signals.
    logic [W_W-1:0]        w_eff;
    logic [IDX_W-1:0]      sel_cell;
    logic [OFF_W-1:0]      sel_off;
    logic [MUL_W-1:0]      base;
    logic [SUM_W-1:0]      pos;
    logic [Q_W-1:0]        pos_sat;
    logic [Q_W-1:0]        abs_q;
    logic signed [Q_W:0]   mul_x;
    logic signed [Q_W-1:0] mul_y;
    logic signed [2*Q_W:0] mul_full;
    logic signed [PROD_W-1:0] prod_shr;
    logic [ACC_W-1:0]      prod_sh;
    logic [D_W-1:0]        d_src, d_org, d_val;
    logic                  d_out;
    logic                  ge;
    logic [IDX_W:0]        quo_next;
    logic [ADDR_W-1:0]     rd_addr;
    logic [COUNT_BITS-1:0] rdata, cnt_inc;
    logic                  in_grid;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;

    // A zero cell width acts as the smallest width.
    assign w_eff = (r_width == '0) ? W_W'(1) : r_width;

    // Point forming: origin + cell * width + offset, saturated to Q4.28.
    assign sel_cell = i_cmd.form_q ? r_cq : r_cp;
    assign sel_off  = i_cmd.form_q ? r_oq : r_op;
    assign base     = MUL_W'(sel_cell) * MUL_W'(r_w);
    assign pos      = {{(SUM_W-Q_W){r_origin[Q_W-1]}}, r_origin}
                    + {2'b00, base}
                    + {{(SUM_W-OFF_W){1'b0}}, sel_off};

    always_comb begin
        if (!pos[SUM_W-1] && (|pos[SUM_W-2:Q_W-1])) begin
            pos_sat = {1'b0, {(Q_W-1){1'b1}}};
        end else if (pos[SUM_W-1] && !(&pos[SUM_W-2:Q_W-1])) begin
            pos_sat = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            pos_sat = pos[Q_W-1:0];
        end
    end

    // Shared map multiplier: alpha * |q| or beta * p.
    assign abs_q    = r_q[Q_W-1] ? (~r_q + 1'b1) : r_q;
    assign mul_x    = i_cmd.mul_a ? $signed({1'b0, abs_q}) : $signed({r_p[Q_W-1], r_p});
    assign mul_y    = i_cmd.mul_a ? $signed(r_alpha) : $signed(r_beta);
    assign mul_full = mul_x * mul_y;

    // Product back to Q10.28, the accumulator format, rounding toward minus infinity.
    assign prod_shr = r_prod >>> FRAC_BITS;
    assign prod_sh  = prod_shr[ACC_W-1:0];

    // Cell search setup: distance above the origin and range test.
    assign d_src = i_cmd.div_init_row ? {{(D_W-ACC_W){r_acc[ACC_W-1]}}, r_acc}
                                      : {{(D_W-Q_W){r_q[Q_W-1]}}, r_q};
    assign d_org = {{(D_W-Q_W){r_origin[Q_W-1]}}, r_origin};
    assign d_val = d_src - d_org;
    assign d_out = d_val[D_W-1] || (d_val == '0) || (d_val >= r_lim);

    // One restoring divide step per cycle.
    assign ge       = (r_rem >= r_dvs);
    assign quo_next = {r_quo, ge};

    // Counter address and saturating increment.
    assign rd_addr = (r_opcode == OP_READ)
                   ? ADDR_W'(r_cq) * ADDR_W'(GRID_SIDE) + ADDR_W'(r_cp)
                   : ADDR_W'(r_row) * ADDR_W'(GRID_SIDE) + ADDR_W'(r_col);
    assign in_grid = ({1'b0, r_cq} < (IDX_W+1)'(GRID_SIDE))
                  && ({1'b0, r_cp} < (IDX_W+1)'(GRID_SIDE));
    assign cnt_inc = (&rdata) ? rdata : rdata + 1'b1;

    // RAM write: clearing sweep or counter update on a hit.
    assign ram_we    = i_cmd.clr_step
                    || (i_cmd.mem_cap && (r_opcode == OP_MAP) && !r_miss);
    assign ram_waddr = i_cmd.clr_step ? r_clr_addr : r_addr;
    assign ram_wdata = i_cmd.clr_step ? '0 : cnt_inc;

    lmch_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    assign o_status.clr_last = (r_clr_addr == ADDR_W'(CELLS - 1));

    // Result selection by operation.
    always_comb begin
        n_out_count = '0;
        n_out_bin_q = '0;
        n_out_bin_p = '0;
        n_out_hit   = 1'b0;
        case (t_opcode'(r_opcode))
            OP_MAP: begin
                if (!r_miss) begin
                    n_out_count = r_cnt;
                    n_out_bin_q = r_row;
                    n_out_bin_p = r_col;
                    n_out_hit   = 1'b1;
                end
            end
            OP_READ: begin
                n_out_count = r_cnt;
                n_out_bin_q = r_cq;
                n_out_bin_p = r_cp;
            end
            default: begin
                n_out_count = '0;
            end
        endcase
    end

    // Configuration registers and the sweep address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha    <= ALPHA_RST;
            r_beta     <= BETA_RST;
            r_origin   <= ORIGIN_RST;
            r_width    <= WIDTH_RST;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ALPHA:  r_alpha  <= i_cfg_wdata;
                    CFG_BETA:   r_beta   <= i_cfg_wdata;
                    CFG_ORIGIN: r_origin <= i_cfg_wdata;
                    CFG_WIDTH:  r_width  <= i_cfg_wdata[W_W-1:0];
                    default:    r_width  <= r_width;
                endcase
            end
            if (i_cmd.clr_step) begin
                if (o_status.clr_last) begin
                    r_clr_addr <= '0;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_opcode <= i_opcode;
            r_cq     <= i_cell_q;
            r_cp     <= i_cell_p;
            r_oq     <= i_offset_q;
            r_op     <= i_offset_p;
            r_w      <= w_eff;
            r_lim    <= D_W'(GRID_SIDE) * D_W'(w_eff);
            r_miss   <= 1'b0;
        end
        if (i_cmd.form_q) begin
            r_q <= pos_sat;
        end
        if (i_cmd.form_p) begin
            r_p <= pos_sat;
        end
        if (i_cmd.mul_a || i_cmd.mul_b) begin
            r_prod <= mul_full[PROD_W-1:0];
        end
        if (i_cmd.mul_b) begin
            r_acc <= ACC_ONE - prod_sh;
        end
        if (i_cmd.acc_add) begin
            r_acc <= r_acc + prod_sh;
        end
        if (i_cmd.div_init_row || i_cmd.div_init_col) begin
            r_rem  <= d_val;
            r_dvs  <= D_W'(r_w) << (IDX_W - 1);
            r_quo  <= '0;
            r_miss <= r_miss || d_out;
        end
        if (i_cmd.div_step) begin
            if (ge) begin
                r_rem <= r_rem - r_dvs;
            end
            r_dvs <= r_dvs >> 1;
            r_quo <= quo_next[IDX_W-1:0];
        end
        if (i_cmd.save_row) begin
            r_row  <= r_quo;
            r_miss <= r_miss || (r_rem == '0);
        end
        if (i_cmd.save_col) begin
            r_col  <= r_quo;
            r_miss <= r_miss || (r_rem == '0);
        end
        if (i_cmd.mem_rd) begin
            r_addr    <= rd_addr;
            r_in_grid <= in_grid;
        end
        if (i_cmd.mem_cap) begin
            if (r_opcode == OP_MAP) begin
                r_cnt <= cnt_inc;
            end else begin
                r_cnt <= r_in_grid ? rdata : '0;
            end
        end
        if (i_cmd.out_load) begin
            r_out_count <= n_out_count;
            r_out_bin_q <= n_out_bin_q;
            r_out_bin_p <= n_out_bin_p;
            r_out_hit   <= n_out_hit;
        end
    end

    assign o_count = r_out_count;
    assign o_bin_q = r_out_bin_q;
    assign o_bin_p = r_out_bin_p;
    assign o_hit   = r_out_hit;

`ifndef ASSERT_OFF
    // Outside the sweep, the RAM is written only by a counter update.
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && !i_cmd.clr_step) |-> i_cmd.mem_cap)
        else $error("counter RAM written outside an update");

    // The sweep address rests at zero between sweeps.
    a_sweep_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.clr_step |-> (r_clr_addr == '0))
        else $error("sweep address not at zero while idle");

    // A hit always reports a nonzero count.
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && (r_opcode == OP_MAP) && !r_miss)
            |=> (r_out_hit && (r_out_count != '0)))
        else $error("hit reported with zero count");
`endif

endmodule

// ===== rtl/lozi_map_cell_histogram_top.sv =====
// Map word: the shared restoring divider finds the row and then the column,
// one quotient bit a cycle.
// Read word: the count comes through the registered read of the counter RAM. Unused opcode: an all-zero result.
// Clear word: one counter per cycle through the write port.
// One word is in work at a time; a finished word waits in the output register meanwhile.
// Reset is synchronous; after it a sweep zeroes every counter.
// ----------------------------------------------------------------------------
// Lozi map cell histogram
// Maps sample points one Lozi map step forward, finds the target grid
// cell and counts it in a saturating counter; also clears and reads the
// counters.
// ----------------------------------------------------------------------------
module lozi_map_cell_histogram_top
    import lmch_pkg::*;
#(
    parameter int GRID_SIDE  = 64,
    parameter int COUNT_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]             i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_opcode,
    input  logic [$clog2(GRID_SIDE)-1:0] i_cell_q,
    input  logic [$clog2(GRID_SIDE)-1:0] i_cell_p,
    input  logic [OFF_W-1:0]             i_offset_q,
    input  logic [OFF_W-1:0]             i_offset_p,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [COUNT_BITS-1:0]        o_count,
    output logic [$clog2(GRID_SIDE)-1:0] o_bin_q,
    output logic [$clog2(GRID_SIDE)-1:0] o_bin_p,
    output logic                         o_hit
);

    t_lmch_cmd    cmd;
    t_lmch_status status;

    // Sequencer.
    lmch_ctrl #(
        .GRID_SIDE (GRID_SIDE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // Arithmetic, counters and output register.
    lmch_dp #(
        .GRID_SIDE  (GRID_SIDE),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_opcode    (i_opcode),
        .i_cell_q    (i_cell_q),
        .i_cell_p    (i_cell_p),
        .i_offset_q  (i_offset_q),
        .i_offset_p  (i_offset_p),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_count     (o_count),
        .o_bin_q     (o_bin_q),
        .o_bin_p     (o_bin_p),
        .o_hit       (o_hit)
    );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Lozi map cell histogram testbench
// Feeds clear, map, read and unused words to the histogram block under
// several map settings, with random idle cycles on both channels. Each
// accepted word is run through a local model of the map and the counter
// array, and every result word is checked field by field against it.
// ----------------------------------------------------------------------------
module tb_top;
    import lmch_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID       = 64;
    localparam int COUNT_BITS = 24;
    localparam int IDX_W      = $clog2(GRID);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [OFF_W-1:0]      OFF_MAX    = {OFF_W{1'b1}};
    localparam logic [1:0]            OP_UNUSED  = 2'd3;
    localparam int                    HOLD_CYCLES = 300;
    localparam int                    DRAIN_CYCLES = 40;
    localparam int unsigned           TIMEOUT_NS = 10_000_000;

    // One input word and one result word.
    typedef struct packed {
        logic [1:0]       opcode;
        logic [IDX_W-1:0] cell_q;
        logic [IDX_W-1:0] cell_p;
        logic [OFF_W-1:0] offset_q;
        logic [OFF_W-1:0] offset_p;
    } t_word;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [IDX_W-1:0]      bin_q;
        logic [IDX_W-1:0]      bin_p;
        logic                  hit;
    } t_tally;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic             cfg_we    = 1'b0;
    t_cfg_idx         cfg_idx   = CFG_ALPHA;
    logic [CFG_W-1:0] cfg_wdata = '0;

    logic  in_valid = 1'b0;
    logic  in_ready;
    t_word offer    = '0;

    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [COUNT_BITS-1:0] res_count;
    logic [IDX_W-1:0]      res_bin_q;
    logic [IDX_W-1:0]      res_bin_p;
    logic                  res_hit;

    // Pacing controls set by the stimulus process.
    logic steady_run = 1'b0;
    logic hold_req   = 1'b0;
    logic hold_done  = 1'b0;
    int   hold_left  = 0;

    // Local copy of the map settings and of the counter array.
    int                    alpha_r  = int'(ALPHA_RST);
    int                    beta_r   = int'(BETA_RST);
    int                    origin_r = int'(ORIGIN_RST);
    int unsigned           width_r  = int'(WIDTH_RST);
    logic [COUNT_BITS-1:0] tally_ram [GRID*GRID] = '{default: '0};

    t_word                pending_words [$];
    t_tally               tally_due [$];
    t_word                map_history [$];
    logic [2*IDX_W-1:0]   hit_cells [$];
    int                   mismatches = 0;

    lozi_map_cell_histogram_top #(
        .GRID_SIDE  (GRID),
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_opcode    (offer.opcode),
        .i_cell_q    (offer.cell_q),
        .i_cell_p    (offer.cell_p),
        .i_offset_q  (offer.offset_q),
        .i_offset_p  (offer.offset_p),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_count     (res_count),
        .o_bin_q     (res_bin_q),
        .o_bin_p     (res_bin_p),
        .o_hit       (res_hit)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // A width of zero behaves as the smallest step.
    function automatic longint width_eff();
        return (width_r == 0) ? 64'sd1 : longint'(width_r);
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
        if (v < -longint'(64'sh8000_0000)) return -longint'(64'sh8000_0000);
        return v;
    endfunction

    // A value lies in cell n only strictly between two bounds, inside the grid.
    function automatic logic locate(input longint v, output logic [IDX_W-1:0] n);
        longint d;
        longint w;
        longint k;
        w = width_eff();
        d = v - longint'(origin_r);
        k = (d > 0) ? d / w : 64'sd0;
        n = IDX_W'(k);
        return (d > 0) && (d % w != 0) && (k < GRID);
    endfunction

    // One Lozi step from the sample point; floor shifts bring products to Q4.28.
    function automatic logic land(input t_word wd, output logic [IDX_W-1:0] r,
                                  output logic [IDX_W-1:0] c);
        longint w;
        longint q;
        longint p;
        longint aq;
        longint qn;
        logic   hr;
        logic   hc;
        w  = width_eff();
        q  = clamp32(longint'(origin_r) + longint'(wd.cell_q) * w + longint'(wd.offset_q));
        p  = clamp32(longint'(origin_r) + longint'(wd.cell_p) * w + longint'(wd.offset_p));
        aq = (q < 0) ? -q : q;
        qn = (64'sd1 <<< FRAC_BITS) - ((longint'(alpha_r) * aq) >>> FRAC_BITS)
             + ((longint'(beta_r) * p) >>> FRAC_BITS);
        hr = locate(qn, r);
        hc = locate(q, c);
        return hr && hc;
    endfunction

    // Applies one accepted word to the counter array and returns its result.
    function automatic t_tally tally_word(input t_word wd);
        t_tally           t;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        int               k;
        t = '0;
        case (wd.opcode)
            OP_CLEAR: begin
                foreach (tally_ram[i]) tally_ram[i] = '0;
            end
            OP_MAP: begin
                if (land(wd, r, c)) begin
                    k = int'(r) * GRID + int'(c);
                    if (tally_ram[k] != COUNT_MAX) tally_ram[k] = tally_ram[k] + 1'b1;
                    t.count = tally_ram[k];
                    t.bin_q = r;
                    t.bin_p = c;
                    t.hit   = 1'b1;
                end
            end
            OP_READ: begin
                t.count = tally_ram[int'(wd.cell_q) * GRID + int'(wd.cell_p)];
                t.bin_q = wd.cell_q;
                t.bin_p = wd.cell_p;
            end
            default: begin
            end
        endcase
        return t;
    endfunction

    function automatic t_word form_word(input logic [1:0] opc, input logic [IDX_W-1:0] cq,
                                        input logic [IDX_W-1:0] cp,
                                        input logic [OFF_W-1:0] oq,
                                        input logic [OFF_W-1:0] op);
        t_word wd;
        wd = '{opcode: opc, cell_q: cq, cell_p: cp, offset_q: oq, offset_p: op};
        return wd;
    endfunction

    // Queues a word and remembers map words and the cells they reach.
    function automatic void queue_word(input t_word wd);
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        pending_words.push_back(wd);
        if (wd.opcode == OP_MAP) begin
            map_history.push_back(wd);
            if (map_history.size() > 32) void'(map_history.pop_front());
            if (land(wd, r, c)) begin
                hit_cells.push_back({r, c});
                if (hit_cells.size() > 64) void'(hit_cells.pop_front());
            end
        end
    endfunction

    // Mostly samples inside their source cell, plus clears, reads, repeats and noise.
    function automatic t_word random_word();
        t_word       wd;
        int unsigned pick;
        pick        = $urandom_range(0, 999);
        wd.opcode   = OP_MAP;
        wd.cell_q   = IDX_W'($urandom_range(0, GRID - 1));
        wd.cell_p   = IDX_W'($urandom_range(0, GRID - 1));
        wd.offset_q = OFF_W'($urandom_range(0, 32'(width_eff() - 1)));
        wd.offset_p = OFF_W'($urandom_range(0, 32'(width_eff() - 1)));
        if (pick < 5) begin
            wd.opcode = OP_CLEAR;
        end else if (pick < 150) begin
            wd.opcode   = OP_READ;
            wd.offset_q = OFF_W'($urandom);
            wd.offset_p = OFF_W'($urandom);
            if (hit_cells.size() != 0 && $urandom_range(0, 3) != 0)
                {wd.cell_q, wd.cell_p} = hit_cells[$urandom_range(0, hit_cells.size() - 1)];
        end else if (pick < 250) begin
            wd.offset_q = OFF_W'($urandom);
            wd.offset_p = OFF_W'($urandom);
            if ($urandom_range(0, 3) == 0) wd.opcode = OP_READ;
            else if ($urandom_range(0, 2) == 0) wd.opcode = OP_UNUSED;
        end else if (pick < 400 && map_history.size() != 0) begin
            wd = map_history[$urandom_range(0, map_history.size() - 1)];
        end
        return wd;
    endfunction

    function automatic void flag(input string msg);
        mismatches++;
        $error("%s", msg);
    endfunction

    function automatic void check_field(input string fname, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
            flag($sformatf("%s mismatch: expected %0d, got %0d", fname, want, got));
    endfunction

    task automatic put_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= v;
    endtask

    // Writes all four map registers; only called with nothing in flight.
    task automatic load_config(input logic [CFG_W-1:0] a, input logic [CFG_W-1:0] b,
                               input logic [CFG_W-1:0] o, input logic [CFG_W-1:0] w);
        alpha_r  = int'(a);
        beta_r   = int'(b);
        origin_r = int'(o);
        width_r  = int'(w[W_W-1:0]);
        hit_cells.delete();
        map_history.delete();
        put_reg(CFG_ALPHA, a);
        put_reg(CFG_BETA, b);
        put_reg(CFG_ORIGIN, o);
        put_reg(CFG_WIDTH, w);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_words.size() != 0 || in_valid || tally_due.size() != 0);
    endtask

    task automatic run_phase(input int count);
        @(negedge clk);
        repeat (count) queue_word(random_word());
        wait_drained();
    endtask

    // Sender: offers the next queued word, idling at random between words.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) tally_due.push_back(tally_word(offer));
            if (!in_valid || in_ready) begin
                if (pending_words.size() != 0 && (steady_run || $urandom_range(0, 99) >= 15)) begin
                    offer    <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result word and paces ready, with one long hold-off.
    always @(posedge clk) begin : sink
        t_tally due;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (tally_due.size() == 0) begin
                    flag($sformatf("result word with none expected: count %0d bin_q %0d %s",
                                   res_count, res_bin_q,
                                   $sformatf("bin_p %0d hit %0b", res_bin_p, res_hit)));
                end else begin
                    due = tally_due.pop_front();
                    check_field("count", due.count, res_count);
                    check_field("bin_q", due.bin_q, res_bin_q);
                    check_field("bin_p", due.bin_p, res_bin_p);
                    check_field("hit", due.hit, res_hit);
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= steady_run || ($urandom_range(0, 99) >= 15);
            end
        end
    end

    initial begin : stimulus
        logic [OFF_W-1:0]   half;
        logic [OFF_W-1:0]   wbound;
        logic [2*IDX_W-1:0] seen;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset settings.
        @(negedge clk);
        half   = OFF_W'(width_eff() / 2);
        wbound = OFF_W'(width_eff());
        queue_word(form_word(OP_READ, 0, 0, 0, 0));
        queue_word(form_word(OP_READ, 63, 63, OFF_MAX, OFF_MAX));
        queue_word(form_word(OP_UNUSED, 63, 63, OFF_MAX, OFF_MAX));
        // Source point on the lower grid bound, then on an inner bound.
        queue_word(form_word(OP_MAP, 0, 0, 0, 0));
        queue_word(form_word(OP_MAP, 32, 32, 0, 0));
        // Largest offsets push the source point far out, the first one to the saturation limit.
        queue_word(form_word(OP_MAP, 63, 63, OFF_MAX, OFF_MAX));
        queue_word(form_word(OP_MAP, 0, 0, OFF_MAX, 0));
        queue_word(form_word(OP_MAP, 0, 63, 0, OFF_MAX));
        // The same sample three times counts up one cell.
        repeat (3) queue_word(form_word(OP_MAP, 31, 20, half, half));
        seen = (hit_cells.size() != 0) ? hit_cells[$] : '0;
        queue_word(form_word(OP_READ, seen[2*IDX_W-1:IDX_W], seen[IDX_W-1:0], 0, 0));
        // An offset of one full width lands the new p exactly on a cell bound.
        queue_word(form_word(OP_MAP, 31, 20, wbound, half));
        queue_word(form_word(OP_MAP, 10, 50, 1, 1));
        queue_word(form_word(OP_CLEAR, 0, 0, 0, 0));
        queue_word(form_word(OP_READ, seen[2*IDX_W-1:IDX_W], seen[IDX_W-1:0], 0, 0));
        queue_word(form_word(OP_MAP, 31, 20, half, half));
        queue_word(form_word(OP_READ, seen[2*IDX_W-1:IDX_W], seen[IDX_W-1:0], OFF_MAX, 0));
        queue_word(form_word(OP_MAP, 5, 60, 31'h5555_5555, 31'h2AAA_AAAA));
        queue_word(form_word(OP_READ, 0, 63, 0, OFF_MAX));
        queue_word(form_word(OP_READ, 63, 0, OFF_MAX, 0));
        queue_word(form_word(OP_UNUSED, 0, 0, 0, 0));
        wait_drained();

        // Reset settings: the receiver stalls long once, then the sender pauses.
        hold_req <= 1'b1;
        run_phase(250);
        run_phase(250);

        // Most negative slope, largest coupling, lowest origin, widest cells.
        load_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        run_phase(40);

        // Opposite extremes with the narrowest cell; the unused width bit is set.
        load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001);
        run_phase(40);

        // A written width of zero.
        load_config(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        run_phase(30);

        // Random settings near the classic map; the first runs with no idling.
        steady_run <= 1'b1;
        repeat (3) begin
            load_config($urandom_range(322122547, 523449139),
                        32'($urandom_range(0, 268435456)) - 32'd134217728,
                        -32'($urandom_range(295279001, 402653184)),
                        $urandom_range(8724152, 13086228));
            run_phase(130);
            steady_run <= 1'b0;
        end

        load_config(ALPHA_RST, BETA_RST, ORIGIN_RST, 32'(WIDTH_RST));
        run_phase(100);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && tally_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Timeout guard.
    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lmch_pkg.sv
rtl/lmch_ram.sv
rtl/lmch_ctrl.sv
rtl/lmch_dp.sv
rtl/lozi_map_cell_histogram_top.sv
tb/tb_top.sv
